// ----- src/sfe_pkg.sv -----
// ----------------------------------------------------------------------------
// sfe_pkg: shared types and constants for the sinusoid fit error block
// Holds payload structs, status and mode codes, sequencer states and the
// quarter-wave sine polynomial used to build the sine table.
// ----------------------------------------------------------------------------
package sfe_pkg;

	localparam int MaxSamples     = 1024;
	localparam int SampleBits     = 16;
	localparam int SineTableDepth = 1024;

	localparam logic [63:0] Q30One = 64'd1073741824;
	localparam logic [63:0] Sc1    = 64'd1686629713;
	localparam logic [63:0] Sc3    = 64'd693598668;
	localparam logic [63:0] Sc5    = 64'd85569306;
	localparam logic [63:0] Sc7    = 64'd5026994;
	localparam logic [63:0] Sc9    = 64'd172274;

	localparam logic [17:0] ErrMax = 18'd131072;

	typedef enum logic [1:0] {
		STATUS_OK      = 2'd0,
		STATUS_BADMODE = 2'd1,
		STATUS_FLAT    = 2'd2
	} status_t;

	typedef enum logic [1:0] {
		MODE_INVALID = 2'd0,
		MODE_SINE    = 2'd1,
		MODE_COSINE  = 2'd2,
		MODE_TROUGH  = 2'd3
	} mode_t;

	localparam logic [0:0] REG_FIT_MODE = 1'd0;

	typedef struct packed {
		logic signed [15:0] sample;
		logic               last_sample;
	} in_item_t;

	typedef struct packed {
		logic [17:0] fit_error;
		logic [1:0]  fit_status;
	} out_item_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_LAUNCH,
		ST_PHASE,
		ST_READ,
		ST_SCALE,
		ST_SQUARE,
		ST_MEAN,
		ST_ROOT,
		ST_DONE
	} seq_state_t;

	// sin(pi/2 * t), t in Q30, result Q16
	function automatic logic signed [17:0] quarter_sine(input logic [63:0] t);
		logic [63:0] t2;
		logic [63:0] p;
		logic [63:0] v;
		t2 = (t * t) >> 30;
		p  = Sc9;
		p  = Sc7 - ((p * t2) >> 30);
		p  = Sc5 - ((p * t2) >> 30);
		p  = Sc3 - ((p * t2) >> 30);
		p  = Sc1 - ((p * t2) >> 30);
		v  = (((p * t) >> 30) + 64'd8192) >> 14;
		if (v > 64'd65536) v = 64'd65536;
		return 18'(v);
	endfunction

	function automatic logic signed [17:0] sine_entry(input int k, input int depth);
		logic [63:0] q4;
		logic [63:0] quad;
		logic [63:0] r;
		logic [63:0] t;
		logic signed [17:0] v;
		q4   = 64'(4 * k);
		quad = q4 / 64'(depth);
		r    = q4 % 64'(depth);
		t    = (r << 30) / 64'(depth);
		if (quad == 64'd1 || quad == 64'd3) t = Q30One - t;
		v = quarter_sine(t);
		return (quad >= 64'd2) ? -v : v;
	endfunction

endpackage

// ----- src/sfe_front.sv -----
// ----------------------------------------------------------------------------
// sfe_front: record loader
// Accepts samples, tracks count, minimum and maximum, writes the store and
// hands a closed record descriptor to the back end through a single register.
// ----------------------------------------------------------------------------
module sfe_front #(
	parameter int MAX_SAMPLES = sfe_pkg::MaxSamples,
	parameter int SAMPLE_BITS = sfe_pkg::SampleBits,
	parameter int CW          = $clog2(MAX_SAMPLES + 1),
	parameter int AW          = $clog2(MAX_SAMPLES)
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          push,
	output logic                          full,
	input  logic signed [SAMPLE_BITS-1:0] sample,
	input  logic                          last_sample,
	// record hand-off
	output logic                          rec_valid,
	input  logic                          rec_take,
	output logic [CW-1:0]                 rec_count,
	output logic signed [SAMPLE_BITS-1:0] rec_min,
	output logic signed [SAMPLE_BITS-1:0] rec_max,
	// store write port
	output logic                          wr_en,
	output logic [AW-1:0]                 wr_addr,
	output logic signed [SAMPLE_BITS-1:0] wr_data
);
	import sfe_pkg::*;

	logic [CW-1:0]                 count_q;
	logic signed [SAMPLE_BITS-1:0] min_q, max_q;
	logic                          hold_q;
	logic                          acc, store_ok;

	// One record in flight: the store holds a single record at a time.
	assign full     = hold_q;
	assign acc      = push && !full;
	assign store_ok = count_q < CW'(MAX_SAMPLES);

	assign wr_en   = acc && store_ok;
	assign wr_addr = count_q[AW-1:0];
	assign wr_data = sample;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q   <= '0;
			min_q     <= '0;
			max_q     <= '0;
			hold_q    <= 1'b0;
			rec_valid <= 1'b0;
			rec_count <= '0;
			rec_min   <= '0;
			rec_max   <= '0;
		end else begin
			if (rec_take) begin
				rec_valid <= 1'b0;
				hold_q    <= 1'b0;
			end
			if (acc) begin
				if (last_sample) begin
					hold_q    <= 1'b1;
					rec_valid <= 1'b1;
					count_q   <= '0;
					min_q     <= '0;
					max_q     <= '0;
					rec_count <= store_ok ? count_q + 1'b1 : count_q;
					if (!store_ok) begin
						rec_min <= min_q;
						rec_max <= max_q;
					end else if (count_q == '0) begin
						rec_min <= sample;
						rec_max <= sample;
					end else begin
						rec_min <= (sample < min_q) ? sample : min_q;
						rec_max <= (sample > max_q) ? sample : max_q;
					end
				end else if (store_ok) begin
					count_q <= count_q + 1'b1;
					if (count_q == '0) begin
						min_q <= sample;
						max_q <= sample;
					end else begin
						if (sample < min_q) min_q <= sample;
						if (sample > max_q) max_q <= sample;
					end
				end
			end
		end
	end
endmodule

// ----- src/sfe_back.sv -----
// ----------------------------------------------------------------------------
// sfe_back: fit pass
// Walks the stored record, scales each sample, subtracts the reference wave,
// accumulates squared differences, then divides and takes the root serially.
// ----------------------------------------------------------------------------
module sfe_back #(
	parameter int MAX_SAMPLES      = sfe_pkg::MaxSamples,
	parameter int SAMPLE_BITS      = sfe_pkg::SampleBits,
	parameter int SINE_TABLE_DEPTH = sfe_pkg::SineTableDepth,
	parameter int CW               = $clog2(MAX_SAMPLES + 1),
	parameter int AW               = $clog2(MAX_SAMPLES)
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic [1:0]                    fit_mode,
	input  logic                          rec_valid,
	output logic                          rec_take,
	input  logic [CW-1:0]                 rec_count,
	input  logic signed [SAMPLE_BITS-1:0] rec_min,
	input  logic signed [SAMPLE_BITS-1:0] rec_max,
	input  logic                          wr_en,
	input  logic [AW-1:0]                 wr_addr,
	input  logic signed [SAMPLE_BITS-1:0] wr_data,
	output logic                          res_valid,
	input  logic                          res_take,
	output sfe_pkg::out_item_t            res_item
);
	import sfe_pkg::*;

	localparam int TW = $clog2(SINE_TABLE_DEPTH);
	localparam int RW = SAMPLE_BITS + 1;          // range width
	localparam int NW = SAMPLE_BITS + 2;          // numerator width (signed)
	localparam int DW = RW + 16;                  // dividend width for scaling
	localparam int SW = 48;                       // square sum width
	localparam int QW = 36;                       // mean up to 2^34, even for the root

	function automatic logic signed [17:0] tab_at(input int k);
		return sine_entry(k, SINE_TABLE_DEPTH);
	endfunction

	typedef logic signed [17:0] tab_arr_t [SINE_TABLE_DEPTH];
	function automatic tab_arr_t build_tab();
		tab_arr_t a;
		for (int k = 0; k < SINE_TABLE_DEPTH; k++) a[k] = tab_at(k);
		return a;
	endfunction

	localparam logic signed [17:0] SINE_TAB [SINE_TABLE_DEPTH] = build_tab();

	// Sample store
	logic signed [SAMPLE_BITS-1:0] mem [MAX_SAMPLES];
	logic signed [SAMPLE_BITS-1:0] rd_data_q;
	logic [AW-1:0]                 rd_addr;

	always_ff @(posedge clk) begin
		if (wr_en) mem[wr_addr] <= wr_data;
		rd_data_q <= mem[rd_addr];
	end

	seq_state_t state_q, state_d;

	logic [CW-1:0]           x_q, n_q;
	logic signed [SAMPLE_BITS-1:0] min_q;
	logic [RW-1:0]           range_q;
	logic [1:0]              mode_q;
	logic [31:0]             phase_q;       // floor(x*2^32/n), updated incrementally
	logic [CW-1:0]           prem_q;        // remainder of that division
	logic [31:0]             pstep_q;       // floor(2^32/n)
	logic [CW-1:0]           psrem_q;       // 2^32 mod n
	logic signed [17:0]      ref_q;
	logic                    neg_q;
	logic [DW-1:0]           dvd_q, quo_q, rem_q;
	logic [6:0]              cnt_q;
	logic [SW-1:0]           sum_q;
	logic signed [18:0]      diff_q;
	logic [QW-1:0]           mean_q;
	logic [QW-1:0]           mrem_q;
	logic [SW-1:0]           mdvd_q;
	logic [17:0]             root_q;
	logic [QW+1:0]           rrem_q;
	logic [QW-1:0]           rsrc_q;
	logic                    init_q;        // phase-step division running
	logic [32:0]             pdvd_q;
	logic                    busy_phase;
	out_item_t               fit_q;         // finished result, waits for the output register
	out_item_t               res_q;

	assign res_item = res_q;
	assign rd_addr  = x_q[AW-1:0];

	// Table index from phase with offset
	logic [31:0] ph_off;
	logic [32+TW-1:0] ph_prod;
	logic [TW:0] tidx;
	always_comb begin
		unique case (mode_t'(mode_q))
			MODE_COSINE: ph_off = 32'h4000_0000;
			MODE_TROUGH: ph_off = 32'hC000_0000;
			default:     ph_off = 32'h0;
		endcase
		ph_prod = {TW'(0), (32'h0 - phase_q) + ph_off} * (32+TW)'(SINE_TABLE_DEPTH)
			+ (32+TW)'(64'h8000_0000);
		tidx = {1'b0, ph_prod[32+TW-1:32]};
	end

	// Numerator of the scaling: 2*(d-min) - range
	logic signed [NW:0] num;
	logic [NW:0] mag;
	assign num = NW'(2) * (NW+1)'(signed'(rd_data_q) - signed'(min_q)) - (NW+1)'(range_q);
	assign mag = num[NW] ? -num : num;

	// Restoring-division step for scaling
	logic [DW:0] sc_try;
	assign sc_try = {rem_q, dvd_q[DW-1]} - {1'b0, (DW)'(range_q)};

	// Mean division step
	logic [QW:0] md_try;
	assign md_try = {mrem_q, mdvd_q[SW-1]} - (QW+1)'(n_q);

	// Phase-step division step (2^32 / n)
	logic [CW:0] pd_try;
	assign pd_try = {psrem_q, pdvd_q[32]} - (CW+1)'(n_q);

	// Root: one result bit per step, digit-by-digit
	logic [QW+1:0] rt_try;
	assign rt_try = {rrem_q[QW-1:0], rsrc_q[QW-1:QW-2]} - {(QW-18)'(0), root_q, 2'b01};

	logic [35:0] sq;
	logic [18:0] dabs;
	assign dabs = diff_q[18] ? 19'(-diff_q) : 19'(diff_q);
	assign sq   = 36'(dabs) * 36'(dabs);

	logic [CW:0] prem_next;
	logic        pcarry;
	always_comb begin
		prem_next = {1'b0, prem_q} + {1'b0, psrem_q};
		pcarry    = prem_next >= (CW+1)'(n_q);
	end

	assign busy_phase = init_q;
	assign rec_take   = (state_q == ST_DONE) && !res_valid;

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE:   if (rec_valid) state_d = ST_LAUNCH;
			ST_LAUNCH: begin
				if (mode_q == MODE_INVALID || range_q == '0) state_d = ST_DONE;
				else state_d = ST_PHASE;
			end
			ST_PHASE:  if (!busy_phase) state_d = ST_READ;
			ST_READ:   state_d = ST_SCALE;
			ST_SCALE:  if (cnt_q == 7'(DW)) state_d = ST_SQUARE;
			ST_SQUARE: state_d = (x_q + 1'b1 == n_q) ? ST_MEAN : ST_READ;
			ST_MEAN:   if (cnt_q == 7'(SW)) state_d = ST_ROOT;
			ST_ROOT:   if (cnt_q == 7'(QW / 2)) state_d = ST_DONE;
			ST_DONE:   if (!res_valid) state_d = ST_IDLE;
			default:   state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			res_valid <= 1'b0;
			init_q    <= 1'b0;
		end else begin
			state_q <= state_d;
			if (res_take) res_valid <= 1'b0;
			if (state_q == ST_LAUNCH && state_d == ST_PHASE) init_q <= 1'b1;
			else if (init_q && cnt_q == 7'd32) init_q <= 1'b0;
			if (state_q == ST_DONE && !res_valid) res_valid <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			ST_IDLE: begin
				n_q     <= rec_count;
				min_q   <= rec_min;
				range_q <= RW'(signed'(rec_max) - signed'(rec_min));
				mode_q  <= fit_mode;
				x_q     <= '0;
				sum_q   <= '0;
				cnt_q   <= '0;
			end
			ST_LAUNCH: begin
				pdvd_q  <= 33'h1_0000_0000;
				psrem_q <= '0;
				pstep_q <= '0;
				cnt_q   <= '0;
				phase_q <= '0;
				prem_q  <= '0;
				if (mode_q == MODE_INVALID) fit_q <= '{fit_error: '0, fit_status: STATUS_BADMODE};
				else if (range_q == '0) fit_q <= '{fit_error: '0, fit_status: STATUS_FLAT};
			end
			ST_PHASE: begin
				if (init_q) begin
					cnt_q  <= cnt_q + 1'b1;
					pdvd_q <= {pdvd_q[31:0], 1'b0};
					if (!pd_try[CW]) begin
						psrem_q <= pd_try[CW-1:0];
						pstep_q <= {pstep_q[30:0], 1'b1};
					end else begin
						psrem_q <= {psrem_q[CW-2:0], pdvd_q[32]};
						pstep_q <= {pstep_q[30:0], 1'b0};
					end
				end
			end
			ST_READ: begin
				ref_q <= SINE_TAB[(tidx >= (TW+1)'(SINE_TABLE_DEPTH)) ? '0 : tidx[TW-1:0]];
				cnt_q <= '0;
			end
			ST_SCALE: begin
				if (cnt_q == '0) begin
					// Dividend never reaches its top bit; preshift so the
					// remaining DW-1 steps cover every dividend bit.
					neg_q <= num[NW];
					dvd_q <= (DW'({mag, 16'h0}) + DW'(range_q >> 1)) << 1;
					rem_q <= '0;
					quo_q <= '0;
					cnt_q <= 7'd1;
				end else if (cnt_q != 7'(DW)) begin
					cnt_q <= cnt_q + 1'b1;
					dvd_q <= {dvd_q[DW-2:0], 1'b0};
					if (!sc_try[DW]) begin
						rem_q <= sc_try[DW-1:0];
						quo_q <= {quo_q[DW-2:0], 1'b1};
					end else begin
						rem_q <= {rem_q[DW-2:0], dvd_q[DW-1]};
						quo_q <= {quo_q[DW-2:0], 1'b0};
					end
				end else begin
					diff_q <= neg_q ? 19'(ref_q) + 19'(quo_q[17:0]) : 19'(ref_q) - 19'(quo_q[17:0]);
				end
			end
			ST_SQUARE: begin
				sum_q <= sum_q + SW'(sq);
				x_q   <= x_q + 1'b1;
				if (pcarry) begin
					phase_q <= phase_q + pstep_q + 32'd1;
					prem_q  <= CW'(prem_next - (CW+1)'(n_q));
				end else begin
					phase_q <= phase_q + pstep_q;
					prem_q  <= prem_next[CW-1:0];
				end
				cnt_q  <= '0;
				mdvd_q <= sum_q + SW'(sq);
				mrem_q <= '0;
				mean_q <= '0;
			end
			ST_MEAN: begin
				if (cnt_q != 7'(SW)) begin
					cnt_q  <= cnt_q + 1'b1;
					mdvd_q <= {mdvd_q[SW-2:0], 1'b0};
					if (!md_try[QW]) begin
						mrem_q <= md_try[QW-1:0];
						mean_q <= {mean_q[QW-2:0], 1'b1};
					end else begin
						mrem_q <= {mrem_q[QW-2:0], mdvd_q[SW-1]};
						mean_q <= {mean_q[QW-2:0], 1'b0};
					end
				end else begin
					cnt_q  <= '0;
					rsrc_q <= mean_q;
					rrem_q <= '0;
					root_q <= '0;
				end
			end
			ST_ROOT: begin
				if (cnt_q != 7'(QW / 2)) begin
					cnt_q  <= cnt_q + 1'b1;
					rsrc_q <= {rsrc_q[QW-3:0], 2'b00};
					if (!rt_try[QW+1]) begin
						rrem_q <= rt_try;
						root_q <= {root_q[16:0], 1'b1};
					end else begin
						rrem_q <= {rrem_q[QW-1:0], rsrc_q[QW-1:QW-2]};
						root_q <= {root_q[16:0], 1'b0};
					end
				end else begin
					// remainder > root rounds the root up to nearest
					fit_q.fit_status <= STATUS_OK;
					if (rrem_q > (QW+2)'(root_q) && root_q != ErrMax)
						fit_q.fit_error <= root_q + 1'b1;
					else
						fit_q.fit_error <= (root_q > ErrMax) ? ErrMax : root_q;
				end
			end
			ST_DONE: begin
				// Move the finished result out once the previous one is popped.
				if (!res_valid) res_q <= fit_q;
			end
			default: ;
		endcase
	end
endmodule

// ----- src/sinusoid_fit_error.sv -----
// ----------------------------------------------------------------------------
// sinusoid_fit_error: RMS misfit of a sample record against one wave period
// Loads a record of signed samples, then scores it against a sine, cosine or
// inverted cosine reference and returns the RMS difference in Q2.16.
// ----------------------------------------------------------------------------
//  channel   | direction | handshake            | payload
//  ----------+-----------+----------------------+---------------------------
//  samples   | in        | push / full          | in_item  (sample, last)
//  results   | out       | pop / empty          | out_item (error, status)
//  config    | in        | APB psel/penable     | fit_mode at address 0
//
//  Load: one sample per cycle while full is low.
//  Score: after the last sample, the record is captured; a bad mode or flat
//  record ends there, else the serial phase-step division runs, then each
//  sample takes a store read, the serial scaling divider and a square, then
//  the serial mean division and the root run. full stays high from the last
//  sample until the score pass finishes and its result moves to the output
//  register, which waits for any earlier result to be popped. Reset clears
//  control; the sample store holds no reset.
module sinusoid_fit_error #(
	parameter int MAX_SAMPLES      = sfe_pkg::MaxSamples,
	parameter int SAMPLE_BITS      = sfe_pkg::SampleBits,
	parameter int SINE_TABLE_DEPTH = sfe_pkg::SineTableDepth
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               push,
	output logic               full,
	input  sfe_pkg::in_item_t  in_item,
	output logic               empty,
	input  logic               pop,
	output sfe_pkg::out_item_t out_item,
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [1:0]         paddr,
	input  logic [31:0]        pwdata,
	output logic [31:0]        prdata,
	output logic               pready
);
	import sfe_pkg::*;

	localparam int CW = $clog2(MAX_SAMPLES + 1);
	localparam int AW = $clog2(MAX_SAMPLES);

	logic [1:0] mode_q;

	// Configuration: single register, written on the access phase.
	assign pready = 1'b1;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= MODE_SINE;
		end else if (psel && penable && pwrite && paddr[1:0] == {REG_FIT_MODE, 1'b0}) begin
			mode_q <= pwdata[1:0];
		end
	end
	assign prdata = {30'h0, mode_q};

	logic                          rec_valid, rec_take;
	logic [CW-1:0]                 rec_count;
	logic signed [SAMPLE_BITS-1:0] rec_min, rec_max;
	logic                          wr_en;
	logic [AW-1:0]                 wr_addr;
	logic signed [SAMPLE_BITS-1:0] wr_data;
	logic                          res_valid, res_take;

	// Front: take samples and close records.
	sfe_front #(.MAX_SAMPLES(MAX_SAMPLES), .SAMPLE_BITS(SAMPLE_BITS)) u_front (
		.clk, .arst_n, .push, .full,
		.sample(SAMPLE_BITS'(in_item.sample)), .last_sample(in_item.last_sample),
		.rec_valid, .rec_take, .rec_count, .rec_min, .rec_max,
		.wr_en, .wr_addr, .wr_data
	);

	// Back: score the closed record and hold the result for pop.
	assign empty    = !res_valid;
	assign res_take = pop && res_valid;

	sfe_back #(
		.MAX_SAMPLES(MAX_SAMPLES), .SAMPLE_BITS(SAMPLE_BITS),
		.SINE_TABLE_DEPTH(SINE_TABLE_DEPTH)
	) u_back (
		.clk, .arst_n, .fit_mode(mode_q),
		.rec_valid, .rec_take, .rec_count, .rec_min, .rec_max,
		.wr_en, .wr_addr, .wr_data,
		.res_valid, .res_take, .res_item(out_item)
	);
endmodule

// ----- src/sfe_checker.sv -----
// ----------------------------------------------------------------------------
// sfe_port_checks: port-level checks for sinusoid_fit_error
// Watches result status rules and queue behavior on the top-level ports.
// ----------------------------------------------------------------------------
module sfe_port_checks (
	input logic               clk,
	input logic               arst_n,
	input logic               empty,
	input logic               pop,
	input sfe_pkg::out_item_t out_item
);
	import sfe_pkg::*;

	// A non-ok status carries a zero error.
	a_status_zero: assert property (@(posedge clk) disable iff (!arst_n)
		!empty && out_item.fit_status != STATUS_OK |-> out_item.fit_error == '0)
		else $error("nonzero error with bad status");

	// Status code three never appears.
	a_status_code: assert property (@(posedge clk) disable iff (!arst_n)
		!empty |-> out_item.fit_status != 2'd3)
		else $error("undefined status code");

	// Error never exceeds two.
	a_err_range: assert property (@(posedge clk) disable iff (!arst_n)
		!empty |-> out_item.fit_error <= ErrMax)
		else $error("error out of range");

	// A waiting result holds until popped.
	a_res_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!empty && !pop |=> !empty && $stable(out_item))
		else $error("result dropped");
endmodule

bind sinusoid_fit_error sfe_port_checks u_sfe_port_checks (
	.clk, .arst_n, .empty, .pop, .out_item
);

// ----- verif/sfe_checker.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// sfe_checker: scoreboard for the sinusoid fit error block
// Watches sample and result transactions and the fit_mode register writes,
// predicts each record's RMS misfit and compares it with the block's output.
// ----------------------------------------------------------------------------
module sfe_checker (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               push,
	input  logic               full,
	input  sfe_pkg::in_item_t  in_item,
	input  logic               empty,
	input  logic               pop,
	input  sfe_pkg::out_item_t out_item,
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [1:0]         paddr,
	input  logic [31:0]        pwdata,
	input  logic               pready,
	output int                 fail_count,
	output int                 pending_count,
	output int                 record_count
);
	import sfe_pkg::*;

	logic signed [17:0]     sine_lut [SineTableDepth];
	logic signed [15:0]     record_buf [MaxSamples];
	int                     rec_len;
	logic signed [15:0]     rec_min, rec_max;
	logic [1:0]             mode_q;
	out_item_t              fit_queue [$];

	function automatic logic [63:0] isqrt_round(input logic [63:0] m);
		logic [63:0] r, b, rem;
		r = 0; b = 64'd1 << 62; rem = m;
		while (b > m) b = b >> 2;
		while (b != 0) begin
			if (rem >= r + b) begin
				rem = rem - (r + b);
				r = (r >> 1) + b;
			end else begin
				r = r >> 1;
			end
			b = b >> 2;
		end
		if (m > r * r + r) r = r + 1;
		return r;
	endfunction

	function automatic out_item_t score_record();
		out_item_t   res;
		logic [63:0] range, mag, acc, idx, ph;
		logic [31:0] offs, phase;
		longint      num, scaled, ref_v, diff;
		res = '0;
		acc = 0;
		if (mode_q == MODE_INVALID) begin
			res.fit_status = STATUS_BADMODE;
		end else if (rec_max == rec_min) begin
			res.fit_status = STATUS_FLAT;
		end else begin
			range = 64'(longint'(rec_max) - longint'(rec_min));
			offs = (mode_q == MODE_SINE) ? 32'h0 :
				(mode_q == MODE_COSINE) ? 32'h4000_0000 : 32'hC000_0000;
			for (int x = 0; x < rec_len; x++) begin
				ph = (64'(x) << 32) / 64'(rec_len);
				phase = (32'd0 - ph[31:0]) + offs;
				idx = (64'(phase) * SineTableDepth + 64'h8000_0000) >> 32;
				if (idx >= SineTableDepth) idx = idx - SineTableDepth;
				ref_v = sine_lut[idx];
				num = 2 * (longint'(record_buf[x]) - longint'(rec_min)) - longint'(range);
				mag = num < 0 ? 64'(-num) : 64'(num);
				mag = (mag * 65536 + range / 2) / range;
				scaled = num < 0 ? -longint'(mag) : longint'(mag);
				diff = ref_v - scaled;
				mag = diff < 0 ? 64'(-diff) : 64'(diff);
				acc = acc + mag * mag;
			end
			mag = isqrt_round(acc / 64'(rec_len));
			if (mag > ErrMax) mag = ErrMax;
			res.fit_error = mag[17:0];
			res.fit_status = STATUS_OK;
		end
		return res;
	endfunction

	initial begin
		for (int k = 0; k < SineTableDepth; k++) sine_lut[k] = sine_entry(k, SineTableDepth);
	end

	assign pending_count = fit_queue.size();

	always @(posedge clk or negedge arst_n) begin
		out_item_t exp_item;
		if (!arst_n) begin
			fail_count <= 0;
			record_count <= 0;
			rec_len = 0;
			rec_min = 0;
			rec_max = 0;
			mode_q = MODE_SINE;
			fit_queue.delete();
		end else begin
			if (psel && penable && pwrite && pready && paddr[1:0] == 2'd0)
				mode_q = pwdata[1:0];
			if (!empty && pop) begin
				if (fit_queue.size() == 0) begin
					$display("%0t: unexpected result err=%0d status=%0d", $time,
						out_item.fit_error, out_item.fit_status);
					fail_count <= fail_count + 1;
				end else begin
					exp_item = fit_queue.pop_front();
					if (exp_item !== out_item) begin
						$display("%0t: mismatch expected err=%0d status=%0d actual err=%0d status=%0d",
							$time, exp_item.fit_error, exp_item.fit_status,
							out_item.fit_error, out_item.fit_status);
						fail_count <= fail_count + 1;
					end
				end
			end
			if (push && !full) begin
				if (rec_len < MaxSamples) begin
					if (rec_len == 0) begin
						rec_min = in_item.sample;
						rec_max = in_item.sample;
					end else begin
						if (in_item.sample < rec_min) rec_min = in_item.sample;
						if (in_item.sample > rec_max) rec_max = in_item.sample;
					end
					record_buf[rec_len] = in_item.sample;
					rec_len++;
				end
				if (in_item.last_sample) begin
					fit_queue.push_back(score_record());
					record_count <= record_count + 1;
					rec_len = 0;
					rec_min = 0;
					rec_max = 0;
				end
			end
		end
	end
endmodule

// ----- verif/tb.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb: stimulus and verdict for the sinusoid fit error block
// Sends sample records under every fit mode with random gaps and result
// stalls; a separate checker predicts and compares every result.
// ----------------------------------------------------------------------------
module tb;
	import sfe_pkg::*;

	localparam int IdleLimit = 200000;

	logic               clk = 1'b0;
	logic               arst_n = 1'b0;
	logic               push = 1'b0;
	logic               full;
	in_item_t           in_item = '0;
	logic               empty;
	logic               pop = 1'b0;
	out_item_t          out_item;
	logic               psel = 1'b0;
	logic               penable = 1'b0;
	logic               pwrite = 1'b0;
	logic [1:0]         paddr = '0;
	logic [31:0]        pwdata = '0;
	logic [31:0]        prdata;
	logic               pready;
	int                 fail_count, pending_count, record_count;
	int                 idle_cycles = 0;
	int                 sent = 0;

	always #6 clk = ~clk;

	sinusoid_fit_error i_dut (.*);

	sfe_checker i_checker (.*);

	// Watchdog: count cycles with no transaction on either channel.
	always @(posedge clk) begin
		if ((push && !full) || (pop && !empty)) idle_cycles <= 0;
		else idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= IdleLimit) begin
			$display("tb failed");
			$finish;
		end
	end

	// Result side: hold pop low for a random stall, sometimes skipped, before each pop.
	initial begin
		int stall;
		@(posedge arst_n);
		forever begin
			stall = $urandom_range(0, 8);
			if ($urandom_range(0, 3) == 0) stall = 0;
			if (stall != 0) begin
				pop <= 1'b0;
				repeat (stall) @(negedge clk);
			end
			pop <= 1'b1;
			do @(posedge clk); while (empty);
			@(negedge clk);
		end
	end

	task automatic write_mode(input logic [1:0] mode);
		@(negedge clk);
		psel <= 1'b1; pwrite <= 1'b1; paddr <= {REG_FIT_MODE, 1'b0}; pwdata <= 32'(mode);
		@(negedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		@(negedge clk);
		psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
	endtask

	// Hold until nothing is pending, then let the scoring pass drain.
	task automatic drain();
		while (pending_count != 0) @(negedge clk);
		repeat (64) @(negedge clk);
	endtask

	// Send one sample; a random gap, possibly zero, comes first unless burst mode is asked.
	task automatic send_sample(input logic signed [15:0] s, input bit last, input bit burst);
		int gap;
		gap = burst ? 0 : $urandom_range(0, 8);
		if (gap != 0) begin
			push <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		push <= 1'b1;
		in_item <= '{sample: s, last_sample: last};
		do @(posedge clk); while (full);
		sent++;
		@(negedge clk);
		if (last) push <= 1'b0;
	endtask

	task automatic send_record(input int len, input int kind);
		logic signed [15:0] s;
		bit burst;
		burst = ($urandom_range(0, 4) == 0);
		@(negedge clk);
		for (int i = 0; i < len; i++) begin
			case (kind)
				0: s = 16'($urandom);
				1: s = 16'sd1234;
				2: s = (i % 2) ? 16'sh7FFF : 16'sh8000;
				default: s = 16'($urandom_range(0, 200)) - 16'sd100;
			endcase
			send_sample(s, i == len - 1, burst);
		end
	endtask

	initial begin
		int len;
		repeat (11) @(negedge clk);
		arst_n <= 1'b1;
		repeat (2) @(negedge clk);

		// Directed: reset mode, extremes, single sample, flat and full store.
		send_record(2, 2);
		send_record(1, 0);
		send_record(3, 1);
		send_record(4, 0);
		drain();
		write_mode(MODE_INVALID);
		send_record(3, 0);
		drain();
		write_mode(MODE_COSINE);
		send_record(5, 2);
		send_record(6, 0);
		drain();
		write_mode(MODE_TROUGH);
		send_record(4, 0);
		drain();
		// Overflow the store: samples past the limit are dropped.
		write_mode(MODE_SINE);
		send_record(MaxSamples + 3, 0);
		drain();

		// Random: mostly short records, a few long ones, mode changes between.
		while (sent < 600 + MaxSamples + 40) begin
			write_mode(2'($urandom_range(0, 3)));
			for (int r = 0; r < 4; r++) begin
				len = ($urandom_range(0, 9) == 0) ? $urandom_range(2, 64) : $urandom_range(1, 8);
				send_record(len, ($urandom_range(0, 9) == 0) ? 1 : ($urandom_range(0, 3) == 0 ? 3 : 0));
			end
			drain();
		end
		drain();

		$display("Covered %0d samples in %0d records across all fit modes,", sent, record_count);
		$display("including flat, single-sample and store-overflow records.");
		if (fail_count == 0) begin
			$display("tb passed");
		end else begin
			$display("tb failed");
		end
		$finish;
	end
endmodule

// ----- files.f -----
src/sfe_pkg.sv
src/sfe_front.sv
src/sfe_back.sv
src/sinusoid_fit_error.sv
src/sfe_checker.sv
verif/sfe_checker.sv
verif/tb.sv
